@@ src/bar_level_ballistics_peak_hold_top_macros.svh @@
// Assertion macros shared by the bar level meter RTL.
`ifndef BAR_LEVEL_BALLISTICS_PEAK_HOLD_TOP_MACROS_SVH
`define BAR_LEVEL_BALLISTICS_PEAK_HOLD_TOP_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define BLPH_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a consequent holds in the cycle of its antecedent.
`define BLPH_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ src/blph_pkg.sv @@
// Types and constants shared by the bar level meter modules.
package blph_pkg;

   localparam int BLPH_MAX_COLUMNS = 256;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_IDX_ROW_COUNT    = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDX_COLUMN_COUNT = 4'd1;

   localparam logic [7:0]  ROW_COUNT_RESET    = 8'd24;
   localparam logic [8:0]  COLUMN_COUNT_RESET = 9'd0;
   localparam logic [14:0] STEP_LIMIT         = 15'd16384;
   localparam logic [15:0] HOLD_TIME          = 16'd22938;

   typedef struct packed {
      logic [7:0]  column_index;
      logic [15:0] sample_level;
      logic        live;
      logic [14:0] frame_step;
      logic [15:0] rise_gain;
      logic [15:0] fall_gain;
   } blph_req_type;

   typedef struct packed {
      logic [7:0] bar_height;
      logic [7:0] peak_row;
      logic       peak_shown;
   } blph_rsp_type;

   // per-column state: height Q8.8, peak Q8.8, hold timer Q0.16
   typedef struct packed {
      logic [15:0] height;
      logic [15:0] peak;
      logic [15:0] hold;
   } blph_state_type;

   typedef struct packed {
      logic [7:0] row_count;
      logic [8:0] column_count;
      logic       clear;
   } blph_geom_type;

   typedef struct packed {
      logic       en;
      logic [7:0] col;
   } blph_rd_type;

   typedef struct packed {
      logic           en;
      logic [7:0]     col;
      blph_state_type data;
   } blph_wr_type;

endpackage

@@ src/blph_csr.sv @@
// Configuration registers for row and column count.
module blph_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [blph_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [blph_pkg::CSR_DATA_W-1:0]  csr_data,
   output blph_pkg::blph_geom_type         geom
);
   import blph_pkg::*;

   logic [7:0] row_count_ff, row_count_in;
   logic [8:0] column_count_ff, column_count_in;
   logic       write_hit;

   assign csr_ready = 1'b1;

   // decode the written word
   always_comb begin
      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      write_hit       = 1'b0;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IDX_ROW_COUNT: begin
               row_count_in = csr_data[7:0];
               write_hit    = 1'b1;
            end
            CSR_IDX_COLUMN_COUNT: begin
               column_count_in = csr_data[8:0];
               write_hit       = 1'b1;
            end
            default: begin
               write_hit = 1'b0;
            end
         endcase
      end
   end

   // hold the geometry
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= ROW_COUNT_RESET;
         column_count_ff <= COLUMN_COUNT_RESET;
      end else begin
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
      end
   end

   assign geom.row_count    = row_count_ff;
   assign geom.column_count = column_count_ff;
   assign geom.clear        = write_hit;

endmodule

@@ src/blph_store.sv @@
// Per-column state memory with entry valid bits.
module blph_store #(
   parameter int MAX_COLUMNS = blph_pkg::BLPH_MAX_COLUMNS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     clear,
   input  blph_pkg::blph_rd_type    rd,
   input  blph_pkg::blph_wr_type    wr,
   output blph_pkg::blph_state_type rd_state
);
   import blph_pkg::*;

   localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

   blph_state_type          mem_ff [MAX_COLUMNS];
   blph_state_type          rd_data_ff;
   logic                    rd_valid_ff;
   logic [MAX_COLUMNS-1:0]  entry_valid_ff, entry_valid_in;
   logic [AW-1:0]           rd_addr;
   logic [AW-1:0]           wr_addr;

   assign rd_addr = AW'(rd.col);
   assign wr_addr = AW'(wr.col);

   // write the state word
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr_addr] <= wr.data;
      end
   end

   // read with registered data
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // mark written entries, drop all on clear
   always_comb begin
      entry_valid_in = entry_valid_ff;
      if (clear) begin
         entry_valid_in = '0;
      end else if (wr.en) begin
         entry_valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         rd_valid_ff    <= 1'b0;
      end else begin
         entry_valid_ff <= entry_valid_in;
         if (rd.en) begin
            rd_valid_ff <= entry_valid_ff[rd_addr];
         end
      end
   end

   // an entry never written reads as zero
   assign rd_state = rd_valid_ff ? rd_data_ff : '0;

endmodule

@@ src/blph_pipe.sv @@
// Ballistics and peak hold pipeline with column hazard interlock.
`include "bar_level_ballistics_peak_hold_top_macros.svh"

module blph_pipe #(
   parameter int MAX_COLUMNS = blph_pkg::BLPH_MAX_COLUMNS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  blph_pkg::blph_req_type   req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output blph_pkg::blph_rsp_type   rsp_payload,
   input  blph_pkg::blph_geom_type  geom,
   output blph_pkg::blph_rd_type    rd,
   input  blph_pkg::blph_state_type rd_state,
   output blph_pkg::blph_wr_type    wr
);
   import blph_pkg::*;

   // stage load enables, back to front
   logic ld1, ld2, ld3, ld4, ld_out;
   logic accept, hazard, req_in_range;

   // stage 1: target and inputs, state arrives from memory
   logic        s1_v_ff, s1_in_range_ff;
   logic [7:0]  s1_col_ff;
   logic [15:0] s1_target_ff, s1_rise_ff, s1_fall_ff;
   logic [14:0] s1_step_ff;
   logic [15:0] target_in;
   logic [14:0] step_in;
   logic [15:0] level_in;
   logic [23:0] scaled;

   // stage 2: product
   logic        s2_v_ff, s2_in_range_ff, s2_dir_ff;
   logic [7:0]  s2_col_ff;
   logic [31:0] s2_prod_ff;
   logic [15:0] s2_h_ff, s2_p_ff, s2_hold_ff;
   logic [14:0] s2_step_ff;
   logic [8:0]  s2_drop_ff;
   logic        dir_in;
   logic [15:0] diff_in, gain_in;
   logic [16:0] drop_sum;

   // stage 3: new height, timer run down
   logic        s3_v_ff, s3_in_range_ff;
   logic [7:0]  s3_col_ff;
   logic [15:0] s3_h_ff, s3_p_ff, s3_hold_ff;
   logic [8:0]  s3_drop_ff;
   logic [32:0] rnd_sum;
   logic [15:0] rnd;
   logic [16:0] h_sum, limit;
   logic [15:0] h_clamp, hold_dec;

   // stage 4: final state
   logic        s4_v_ff, s4_in_range_ff;
   logic [15:0] s4_h_ff, s4_p_ff;
   logic [15:0] p_new, hold_new, p_fall;

   // output register
   logic         out_v_ff;
   blph_rsp_type out_ff, out_in;
   logic [16:0]  bh_sum, pr_sum;
   logic [8:0]   bh9, pr9;
   logic [7:0]   row_m1;

   // advance a stage when it is empty or the next one takes its word
   assign ld_out = !out_v_ff || !rsp_stall;
   assign ld4    = !s4_v_ff || ld_out;
   assign ld3    = !s3_v_ff || ld4;
   assign ld2    = !s2_v_ff || ld3;
   assign ld1    = !s1_v_ff || ld2;

   // hold a word whose column still has a write pending
   assign hazard = (s1_v_ff && s1_in_range_ff && (s1_col_ff == req_payload.column_index)) ||
                   (s2_v_ff && s2_in_range_ff && (s2_col_ff == req_payload.column_index)) ||
                   (s3_v_ff && s3_in_range_ff && (s3_col_ff == req_payload.column_index));
   assign req_stall = !ld1 || hazard;
   assign accept    = req_valid && !req_stall;

   assign rd.en  = accept;
   assign rd.col = req_payload.column_index;

   // qualify the column and compute the target height
   assign req_in_range = (32'(req_payload.column_index) < 32'(geom.column_count)) &&
                         (32'(req_payload.column_index) < 32'(MAX_COLUMNS));
   assign level_in  = req_payload.live ? req_payload.sample_level : 16'd0;
   assign scaled    = 24'(geom.row_count) * 24'(level_in) + 24'd128;
   assign target_in = scaled[23:8];
   assign step_in   = (req_payload.frame_step > STEP_LIMIT) ? STEP_LIMIT
                                                            : req_payload.frame_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (ld1) begin
         s1_v_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         s1_in_range_ff <= req_in_range;
         s1_col_ff      <= req_payload.column_index;
         s1_target_ff   <= target_in;
         s1_step_ff     <= step_in;
         s1_rise_ff     <= req_payload.rise_gain;
         s1_fall_ff     <= req_payload.fall_gain;
      end
   end

   // pick direction and gain, multiply the distance
   assign dir_in   = s1_target_ff > rd_state.height;
   assign diff_in  = dir_in ? (s1_target_ff - rd_state.height) : (rd_state.height - s1_target_ff);
   assign gain_in  = dir_in ? s1_rise_ff : s1_fall_ff;
   assign drop_sum = (17'(s1_step_ff) << 2) + (17'(s1_step_ff) << 1) + 17'd128;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (ld2) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld2) begin
         s2_in_range_ff <= s1_in_range_ff;
         s2_col_ff      <= s1_col_ff;
         s2_dir_ff      <= dir_in;
         s2_prod_ff     <= 32'(diff_in) * 32'(gain_in);
         s2_h_ff        <= rd_state.height;
         s2_p_ff        <= rd_state.peak;
         s2_hold_ff     <= rd_state.hold;
         s2_step_ff     <= s1_step_ff;
         s2_drop_ff     <= drop_sum[16:8];
      end
   end

   // round the move, apply it and clamp to the display height
   assign rnd_sum  = 33'(s2_prod_ff) + 33'd32768;
   assign rnd      = rnd_sum[31:16];
   assign h_sum    = s2_dir_ff ? (17'(s2_h_ff) + 17'(rnd)) : (17'(s2_h_ff) - 17'(rnd));
   assign limit    = (geom.row_count == 8'd0) ? 17'd256 : {1'b0, geom.row_count, 8'd0};
   assign h_clamp  = (h_sum > limit) ? limit[15:0] : h_sum[15:0];
   assign hold_dec = (s2_hold_ff > 16'(s2_step_ff)) ? (s2_hold_ff - 16'(s2_step_ff)) : 16'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (ld3) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld3) begin
         s3_in_range_ff <= s2_in_range_ff;
         s3_col_ff      <= s2_col_ff;
         s3_h_ff        <= h_clamp;
         s3_p_ff        <= s2_p_ff;
         s3_hold_ff     <= hold_dec;
         s3_drop_ff     <= s2_drop_ff;
      end
   end

   // snap, hold or drop the peak
   assign p_fall = (s3_p_ff > 16'(s3_drop_ff)) ? (s3_p_ff - 16'(s3_drop_ff)) : 16'd0;

   always_comb begin
      if (s3_h_ff >= s3_p_ff) begin
         p_new    = s3_h_ff;
         hold_new = HOLD_TIME;
      end else begin
         hold_new = s3_hold_ff;
         if (s3_hold_ff == 16'd0) begin
            p_new = (p_fall > s3_h_ff) ? p_fall : s3_h_ff;
         end else begin
            p_new = s3_p_ff;
         end
      end
   end

   // write back as the word leaves stage 3
   assign wr.en          = ld4 && s3_v_ff && s3_in_range_ff;
   assign wr.col         = s3_col_ff;
   assign wr.data.height = s3_h_ff;
   assign wr.data.peak   = p_new;
   assign wr.data.hold   = hold_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (ld4) begin
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld4) begin
         s4_in_range_ff <= s3_in_range_ff;
         s4_h_ff        <= s3_h_ff;
         s4_p_ff        <= p_new;
      end
   end

   // round and clamp the displayed rows
   assign bh_sum = 17'(s4_h_ff) + 17'd128;
   assign pr_sum = 17'(s4_p_ff) + 17'd128;
   assign bh9    = bh_sum[16:8];
   assign pr9    = pr_sum[16:8];
   assign row_m1 = geom.row_count - 8'd1;

   always_comb begin
      out_in = '0;
      if (s4_in_range_ff && (geom.row_count != 8'd0)) begin
         out_in.bar_height = (bh9 > 9'(geom.row_count)) ? geom.row_count : bh9[7:0];
         out_in.peak_row   = (pr9 > 9'(row_m1)) ? row_m1 : pr9[7:0];
         out_in.peak_shown = out_in.peak_row > out_in.bar_height;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (ld_out) begin
         out_v_ff <= s4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_out) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = out_v_ff;
   assign rsp_payload = out_ff;

   `BLPH_ASSERT_IMPLIES(a_no_read_on_write, clock, reset, accept && wr.en, rd.col != wr.col, "read of a column in the cycle of its write")
   `BLPH_ASSERT_IMPLIES(a_height_in_limit, clock, reset, s4_v_ff && s4_in_range_ff, 17'(s4_h_ff) <= limit, "stored height above the row limit")
   `BLPH_ASSERT_IMPLIES(a_peak_over_height, clock, reset, s4_v_ff && s4_in_range_ff, s4_p_ff >= s4_h_ff, "stored peak below the height")

endmodule

@@ src/bar_level_ballistics_peak_hold_top.sv @@
// Top level of the bar level meter with attack/release ballistics and peak hold.
//
// Each req word carries one column's level sample for one frame with its frame
// step and rise and fall gains; each produces one rsp word with the rounded
// bar height, the peak row and the peak-visible flag, in order.
// Five register stages (stages 1 to 4 and the output register) lie between
// the accepting edge and rsp_valid; one word is taken per cycle while
// req_stall is low. A word whose column still has a state write in flight
// (one of the three stages ahead of write-back) is held by req_stall until
// that write completes.
// The csr port takes a write in every cycle (csr_ready is always high); index
// 0 is the row count, index 1 the column count, and either write forgets all
// column state at once. Write it only while the pipeline is empty.
// Reset sets 24 rows and 0 columns and clears all column state.
// When rsp_stall is high the output word holds and the stages behind it fill
// up before req_stall rises; no word is lost or repeated.
module bar_level_ballistics_peak_hold_top #(
   parameter int MAX_COLUMNS = blph_pkg::BLPH_MAX_COLUMNS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  blph_pkg::blph_req_type           req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output blph_pkg::blph_rsp_type           rsp_payload,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [blph_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [blph_pkg::CSR_DATA_W-1:0]  csr_data
);
   import blph_pkg::*;

   blph_geom_type  geom;
   blph_rd_type    rd;
   blph_wr_type    wr;
   blph_state_type rd_state;

   // geometry registers
   blph_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .geom      (geom)
   );

   // per-column state
   blph_store #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .clear    (geom.clear),
      .rd       (rd),
      .wr       (wr),
      .rd_state (rd_state)
   );

   // ballistics pipeline
   blph_pipe #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_pipe (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .geom        (geom),
      .rd          (rd),
      .rd_state    (rd_state),
      .wr          (wr)
   );

endmodule
